// ===== design/mexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mexp_pkg;
    localparam int ExpBitsDefault = 16;
    localparam int FieldBits = 16;
    localparam int ProdBits = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQ_WAIT,
        ST_MULT,
        ST_MU_WAIT,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start_sq;
        logic start_mu;
        logic emit;
        logic advance;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic red_done;
        logic cur_bit;
        logic is_last;
        logic empty;
    } t_status;
endpackage
`default_nettype wire

// ===== design/modular_exponentiation_trace_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Left-to-right binary modular exponentiation with one result per exponent bit.
// Input channel s_axis: tdata carries base, exponent, exp_length and modulus.
// Output channel m_axis: tdata carries bit_position, exp_bit, prefix_value and
// partial_power; tlast marks the result for bit position zero.
// One item yields min(exp_length, EXP_BITS, 16) results; a zero length yields none.
// Each bit takes a modular square and, for a one bit, a modular multiply. Each
// of these runs on one shared restoring reducer: the product is registered, the
// reducer is started, it reduces the 32-bit product and the remainder is taken
// into the accumulator. The result for the bit is then written to the output
// register. One item is worked on at a time; s_axis_tready is high only
// between items. A result waits in the output register while the next bit is
// computed; if the receiver stalls, the core holds before writing the following
// result. Synchronous active-low reset empties the core and the output register.
module modular_exponentiation_trace_core #(
    parameter int EXP_BITS = mexp_pkg::ExpBitsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // base[15:0], exponent[31:16], exp_length[36:32], modulus[52:37], zeros
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // bit_position[3:0], exp_bit[4], prefix_value[20:5], partial_power[36:21], zeros
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    import mexp_pkg::*;

    t_cmd        w_cmd;
    t_status     w_status;
    logic [39:0] w_result;

    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    mexp_datapath #(.EXP_BITS(EXP_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_base       (s_axis_tdata[15:0]),
        .i_exponent   (s_axis_tdata[31:16]),
        .i_exp_length (s_axis_tdata[36:32]),
        .i_modulus    (s_axis_tdata[52:37]),
        .o_status     (w_status),
        .o_result     (w_result)
    );

    assign m_axis_tdata = {3'b000, w_result[36:0]};
    assign m_axis_tlast = w_result[37];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> s_axis_tready)
        else $error("load outside idle");
    a_onecmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.start_sq, w_cmd.start_mu, w_cmd.emit}))
        else $error("conflicting commands");
endmodule
`default_nettype wire

// ===== design/mexp_modred.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring reduction of a 32-bit value by a 16-bit modulus, one quotient bit per cycle.
module mexp_modred (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_value,
    input  wire logic [15:0] i_modulus,
    output logic             o_done,
    output logic [15:0]      o_rem
);
    import mexp_pkg::*;

    logic [16:0] r_rem, n_rem;
    logic [31:0] r_val;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] w_shift;

    assign w_shift = {r_rem[15:0], r_val[31]};

    always_comb begin
        if (w_shift >= {1'b0, i_modulus}) begin
            n_rem = w_shift - {1'b0, i_modulus};
        end else begin
            n_rem = w_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(ProdBits);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[30:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = (i_modulus == '0) ? '0 : r_rem[15:0];
endmodule
`default_nettype wire

// ===== design/mexp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mexp_datapath #(
    parameter int EXP_BITS = mexp_pkg::ExpBitsDefault
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mexp_pkg::t_cmd    i_cmd,
    input  wire logic [15:0]       i_base,
    input  wire logic [15:0]       i_exponent,
    input  wire logic [4:0]        i_exp_length,
    input  wire logic [15:0]       i_modulus,
    output mexp_pkg::t_status      o_status,
    output logic [39:0]            o_result
);
    import mexp_pkg::*;

    localparam int CapBits = (EXP_BITS < FieldBits) ? EXP_BITS : FieldBits;

    logic [15:0] r_base, r_exp, r_mod, r_acc, r_prefix;
    logic [4:0]  r_pos;
    logic [4:0]  w_len;
    logic [31:0] r_prod;
    logic        r_red_start;
    logic        w_done;
    logic [15:0] w_rem;
    logic [39:0] r_result;

    assign w_len = (i_exp_length > 5'(CapBits)) ? 5'(CapBits) : i_exp_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_start <= 1'b0;
        end else begin
            r_red_start <= i_cmd.start_sq | i_cmd.start_mu;
        end
    end

    // The product is registered before reduction starts.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base   <= i_base;
            r_exp    <= i_exponent;
            r_mod    <= i_modulus;
            r_acc    <= 16'd1;
            r_prefix <= '0;
            r_pos    <= w_len - 5'd1;
        end
        if (i_cmd.start_sq) begin
            r_prod <= r_acc * r_acc;
        end else if (i_cmd.start_mu) begin
            r_prod <= r_acc * r_base;
        end
        if (w_done) begin
            r_acc <= w_rem;
        end
        if (i_cmd.start_sq) begin
            r_prefix <= {r_prefix[14:0], o_status.cur_bit};
        end
        if (i_cmd.emit) begin
            r_result <= {2'b00, (r_pos == 5'd0), r_acc, r_prefix, o_status.cur_bit,
                         r_pos[3:0]};
        end
        if (i_cmd.advance) begin
            r_pos <= r_pos - 5'd1;
        end
    end

    mexp_modred u_red (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_red_start),
        .i_value   (r_prod),
        .i_modulus (r_mod),
        .o_done    (w_done),
        .o_rem     (w_rem)
    );

    assign o_status.red_done = w_done;
    assign o_status.cur_bit  = r_pos[4] ? 1'b0 : r_exp[r_pos[3:0]];
    assign o_status.is_last  = (r_pos == 5'd0);
    assign o_status.empty    = (w_len == 5'd0);
    assign o_result          = r_result;
endmodule
`default_nettype wire

// ===== design/mexp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mexp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire mexp_pkg::t_status i_status,
    output mexp_pkg::t_cmd         o_cmd
);
    import mexp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !i_status.empty) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.start_sq = 1'b1;
                n_state        = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (i_status.red_done) begin
                    n_state = i_status.cur_bit ? ST_MULT : ST_EMIT;
                end
            end
            ST_MULT: begin
                o_cmd.start_mu = 1'b1;
                n_state        = ST_MU_WAIT;
            end
            ST_MU_WAIT: begin
                if (i_status.red_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // The output register takes a result once the previous one is gone.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.advance = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = i_status.is_last ? ST_IDLE : ST_SQUARE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire
